FILE: hdl/llc_pkg.sv
// llc_pkg: shared widths, register indexes, reset values and types for the
// laser line column centroid block. No dependencies.
`timescale 1ns / 1ps

package llc_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int RED_W       = 8;
    localparam int COL_W       = 12;
    localparam int EDGE_W      = 13;
    localparam int HALF_W      = 12;
    localparam int SUM_W       = 36;
    localparam int CNT_W       = 25;
    localparam int AVG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = 2;
    localparam int STEP_W      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HALF     = 2'd2;

    localparam logic [EDGE_W-1:0] RST_FRAME_WIDTH     = 13'd1280;
    localparam logic [RED_W-1:0]  RST_LEVEL_THRESHOLD = 8'd100;
    localparam logic [HALF_W-1:0] RST_WINDOW_HALF     = 12'd100;

    localparam logic [EDGE_W-1:0] WIDTH_LIMIT = EDGE_W'(MAX_WIDTH);
    localparam logic [SUM_W-1:0]  SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX     = {CNT_W{1'b1}};
    localparam logic [STEP_W-1:0] LAST_STEP   = 6'(SUM_W - 1);

    typedef struct packed {
        logic [EDGE_W-1:0] frame_width;
        logic [RED_W-1:0]  level_threshold;
        logic [HALF_W-1:0] window_half;
    } t_cfg;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_frame_sum;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: hdl/llc_front.sv
// llc_front: pixel front end, column counter, search window and hit accumulation.
// Hands one frame total per end-of-frame item to the queue. Uses llc_pkg.
`timescale 1ns / 1ps

module llc_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  llc_pkg::t_cfg             i_cfg,
    input  logic                      i_accept,
    input  logic [llc_pkg::RED_W-1:0] i_red_level,
    input  logic                      i_end_of_frame,
    output logic                      o_push,
    output llc_pkg::t_frame_sum       o_push_data
);

    logic [llc_pkg::COL_W-1:0]  r_column, n_column;
    logic [llc_pkg::COL_W-1:0]  r_left_edge, n_left_edge;
    logic [llc_pkg::EDGE_W-1:0] r_right_edge, n_right_edge;
    logic [llc_pkg::SUM_W-1:0]  r_column_sum, n_column_sum;
    logic [llc_pkg::CNT_W-1:0]  r_hit_count, n_hit_count;

    logic [llc_pkg::EDGE_W-1:0] eff_width;
    logic [llc_pkg::EDGE_W-1:0] right_lim;
    logic [llc_pkg::EDGE_W-1:0] col_ext;
    logic [llc_pkg::EDGE_W-1:0] hi_edge;
    logic [llc_pkg::EDGE_W-1:0] col_inc;
    logic [llc_pkg::SUM_W:0]    sum_ext;
    logic                       hit;

    always_comb begin
        if (i_cfg.frame_width == '0) begin
            eff_width = llc_pkg::EDGE_W'(1);
        end else if (i_cfg.frame_width > llc_pkg::WIDTH_LIMIT) begin
            eff_width = llc_pkg::WIDTH_LIMIT;
        end else begin
            eff_width = i_cfg.frame_width;
        end
        right_lim = (r_right_edge < eff_width) ? r_right_edge : eff_width;
        col_ext   = {1'b0, r_column};
        hit       = (r_column >= r_left_edge) && (col_ext < right_lim) &&
                    (i_red_level > i_cfg.level_threshold);
        hi_edge   = col_ext + {1'b0, i_cfg.window_half};
        col_inc   = col_ext + llc_pkg::EDGE_W'(1);
        sum_ext   = {1'b0, r_column_sum} + (llc_pkg::SUM_W + 1)'(r_column);

        n_left_edge  = r_left_edge;
        n_right_edge = r_right_edge;
        n_column_sum = r_column_sum;
        n_hit_count  = r_hit_count;
        if (hit) begin
            n_left_edge  = (r_column >= i_cfg.window_half) ?
                           (r_column - i_cfg.window_half) : '0;
            n_right_edge = (hi_edge > eff_width) ? eff_width : hi_edge;
            n_column_sum = sum_ext[llc_pkg::SUM_W] ? llc_pkg::SUM_MAX :
                           sum_ext[llc_pkg::SUM_W-1:0];
            if (r_hit_count != llc_pkg::CNT_MAX) begin
                n_hit_count = r_hit_count + llc_pkg::CNT_W'(1);
            end
        end
        n_column = (col_inc >= eff_width) ? '0 : col_inc[llc_pkg::COL_W-1:0];
    end

    assign o_push            = i_accept && i_end_of_frame;
    assign o_push_data.sum   = n_column_sum;
    assign o_push_data.count = n_hit_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_left_edge  <= '0;
            r_right_edge <= llc_pkg::RST_FRAME_WIDTH;
            r_column_sum <= '0;
            r_hit_count  <= '0;
        end else if (i_accept) begin
            if (i_end_of_frame) begin
                r_column     <= '0;
                r_left_edge  <= '0;
                r_right_edge <= eff_width;
                r_column_sum <= '0;
                r_hit_count  <= '0;
            end else begin
                r_column     <= n_column;
                r_left_edge  <= n_left_edge;
                r_right_edge <= n_right_edge;
                r_column_sum <= n_column_sum;
                r_hit_count  <= n_hit_count;
            end
        end
    end

endmodule

FILE: hdl/llc_queue.sv
// llc_queue: two-entry queue of frame totals between front end and divider.
// Register based, push and pop in the same cycle allowed. Uses llc_pkg.
`timescale 1ns / 1ps

module llc_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  llc_pkg::t_frame_sum    i_push_data,
    input  logic                   i_pop,
    output llc_pkg::t_frame_sum    o_head,
    output llc_pkg::t_queue_status o_status
);

    llc_pkg::t_frame_sum r_entry [llc_pkg::QUEUE_DEPTH];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [llc_pkg::QCNT_W-1:0] r_count;

    assign o_head         = r_entry[r_rd_ptr];
    assign o_status.full  = (r_count == llc_pkg::QCNT_W'(llc_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + llc_pkg::QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - llc_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

FILE: hdl/llc_back.sv
// llc_back: bit-serial restoring divider for the mean column and the result
// register. Takes frame totals from llc_queue. Uses llc_pkg.
`timescale 1ns / 1ps

module llc_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  llc_pkg::t_frame_sum       i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [llc_pkg::AVG_W-1:0] o_x_average,
    output logic                      o_found
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [llc_pkg::SUM_W-1:0]   r_dvd;
    logic [llc_pkg::CNT_W-1:0]   r_rem;
    logic [llc_pkg::CNT_W-1:0]   r_den;
    logic [llc_pkg::STEP_W-1:0]  r_step;
    logic                        r_found;
    logic                        r_out_valid;
    logic [llc_pkg::AVG_W-1:0]   r_out_avg;
    logic                        r_out_found;

    logic [llc_pkg::CNT_W:0]     rem_sh;
    logic [llc_pkg::CNT_W:0]     rem_diff;
    logic                        ge;
    logic                        out_free;

    always_comb begin
        rem_sh   = {r_rem, r_dvd[llc_pkg::SUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        ge       = (rem_sh >= {1'b0, r_den});
        out_free = !r_out_valid || i_ready;
        o_pop    = (r_state == S_IDLE) && !i_q_empty;
        n_state  = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_head.count == '0) ? S_PUT : S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dvd   <= (i_head.count == '0) ? '0 : i_head.sum;
                r_den   <= i_head.count;
                r_rem   <= '0;
                r_step  <= llc_pkg::LAST_STEP;
                r_found <= (i_head.count != '0);
            end
            S_DIV: begin
                r_rem  <= ge ? rem_diff[llc_pkg::CNT_W-1:0] : rem_sh[llc_pkg::CNT_W-1:0];
                r_dvd  <= {r_dvd[llc_pkg::SUM_W-2:0], ge};
                r_step <= r_step - llc_pkg::STEP_W'(1);
            end
            default: begin
            end
        endcase
        if (r_state == S_PUT && out_free) begin
            r_out_avg   <= r_dvd[llc_pkg::AVG_W-1:0];
            r_out_found <= r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_x_average = r_out_avg;
    assign o_found     = r_out_found;

endmodule

FILE: hdl/laser_line_column_centroid.sv
// laser_line_column_centroid: top level, configuration registers, front end,
// frame queue and divider back end. Uses llc_pkg, llc_front, llc_queue, llc_back.
//
//   channel   direction  handshake                payload
//   pixel     in         i_valid / o_ready        i_red_level, i_end_of_frame
//   result    out        o_valid / i_ready        o_x_average, o_found
//   config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// pixels are taken one per cycle unless o_ready drops, which it does only while both
// queue entries wait on the divider; the search window and sums update in that cycle.
// each end-of-frame item queues its totals; the divider pops one in S_IDLE, divides in
// S_DIV unless there were no hits, and loads the result register in S_PUT before the
// next pop. synchronous active-low reset; no clearing pass, config is always ready
`timescale 1ns / 1ps

module laser_line_column_centroid (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [llc_pkg::RED_W-1:0]      i_red_level,
    input  logic                           i_end_of_frame,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [llc_pkg::AVG_W-1:0]      o_x_average,
    output logic                           o_found,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [llc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [llc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    llc_pkg::t_cfg          r_cfg;
    llc_pkg::t_frame_sum    push_data;
    llc_pkg::t_frame_sum    q_head;
    llc_pkg::t_queue_status q_status;
    logic                   push;
    logic                   pop;
    logic                   in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !q_status.full;
    assign in_accept   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width     <= llc_pkg::RST_FRAME_WIDTH;
            r_cfg.level_threshold <= llc_pkg::RST_LEVEL_THRESHOLD;
            r_cfg.window_half     <= llc_pkg::RST_WINDOW_HALF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                llc_pkg::CFG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= i_cfg_data;
                end
                llc_pkg::CFG_LEVEL_THRESHOLD: begin
                    r_cfg.level_threshold <= i_cfg_data[llc_pkg::RED_W-1:0];
                end
                llc_pkg::CFG_WINDOW_HALF: begin
                    r_cfg.window_half <= i_cfg_data[llc_pkg::HALF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    llc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (in_accept),
        .i_red_level    (i_red_level),
        .i_end_of_frame (i_end_of_frame),
        .o_push         (push),
        .o_push_data    (push_data)
    );

    llc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_status    (q_status)
    );

    llc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_status.empty),
        .i_head      (q_head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_x_average (o_x_average),
        .o_found     (o_found)
    );

    // an end-of-frame item always leaves a frame total queued
    a_eof_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_end_of_frame) |=> !q_status.empty)
        else $error("end-of-frame item did not reach the queue");

    // no hits gives a zero average
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_x_average == '0))
        else $error("nonzero average with found clear");

    // the queue never reads as full and empty at once, and is never popped while empty
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty) && !(pop && q_status.empty))
        else $error("queue status inconsistent");

endmodule

FILE: tb/llc_centroid_checker.sv
// llc_centroid_checker: watches the pixel, result and config channels of the
// laser line column centroid block, predicts each frame centroid and compares it.
// Depends on llc_pkg.
`timescale 1ns / 1ps

module llc_centroid_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_ready,
    input  logic [llc_pkg::RED_W-1:0]      i_red_level,
    input  logic                           i_end_of_frame,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic [llc_pkg::AVG_W-1:0]      o_x_average,
    input  logic                           o_found,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [llc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [llc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending
);

    typedef struct packed {
        logic [llc_pkg::AVG_W-1:0] x_average;
        logic                      found;
    } t_centroid;

    logic [llc_pkg::EDGE_W-1:0] reg_width;
    logic [llc_pkg::RED_W-1:0]  reg_level;
    logic [llc_pkg::HALF_W-1:0] reg_half;

    logic [llc_pkg::COL_W-1:0]  scan_col;
    logic [llc_pkg::COL_W-1:0]  win_left;
    logic [llc_pkg::EDGE_W-1:0] win_right;
    logic [llc_pkg::SUM_W-1:0]  hit_sum;
    logic [llc_pkg::CNT_W-1:0]  hits;

    t_centroid centroids_due[$];
    t_centroid oldest;

    function automatic logic [llc_pkg::EDGE_W-1:0] usable_width(
        input logic [llc_pkg::EDGE_W-1:0] w
    );
        if (w == '0) begin
            return llc_pkg::EDGE_W'(1);
        end
        if (w > llc_pkg::WIDTH_LIMIT) begin
            return llc_pkg::WIDTH_LIMIT;
        end
        return w;
    endfunction

    task automatic restart_frame();
        scan_col  = '0;
        win_left  = '0;
        win_right = usable_width(reg_width);
        hit_sum   = '0;
        hits      = '0;
    endtask

    task automatic log_mismatch(input string msg);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic track_pixel(input logic [llc_pkg::RED_W-1:0] red, input logic last);
        logic [llc_pkg::EDGE_W-1:0] w;
        logic [llc_pkg::EDGE_W-1:0] win_end;
        logic [llc_pkg::EDGE_W-1:0] reach;
        logic [llc_pkg::EDGE_W-1:0] next_col;
        logic [llc_pkg::SUM_W-1:0]  quotient;
        t_centroid                  centroid;
        w       = usable_width(reg_width);
        win_end = (win_right < w) ? win_right : w;
        if (scan_col >= win_left && scan_col < win_end && red > reg_level) begin
            reach     = scan_col + reg_half;
            win_left  = (scan_col >= reg_half) ? scan_col - reg_half : '0;
            win_right = (reach > w) ? w : reach;
            hit_sum   = (hit_sum > llc_pkg::SUM_MAX - scan_col) ? llc_pkg::SUM_MAX
                                                                : hit_sum + scan_col;
            if (hits != llc_pkg::CNT_MAX) begin
                hits = hits + 1'b1;
            end
        end
        next_col = scan_col + 1'b1;
        scan_col = (next_col >= w) ? '0 : next_col[llc_pkg::COL_W-1:0];
        if (last) begin
            centroid = '0;
            if (hits != '0) begin
                quotient           = hit_sum / hits;
                centroid.x_average = quotient[llc_pkg::AVG_W-1:0];
                centroid.found     = 1'b1;
            end
            centroids_due.push_back(centroid);
            restart_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_width = llc_pkg::RST_FRAME_WIDTH;
            reg_level = llc_pkg::RST_LEVEL_THRESHOLD;
            reg_half  = llc_pkg::RST_WINDOW_HALF;
            restart_frame();
            centroids_due.delete();
        end else begin
            if (i_valid && o_ready) begin
                track_pixel(i_red_level, i_end_of_frame);
            end
            if (o_valid && i_ready) begin
                if (centroids_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected result: x_average %0d found %0d",
                                           o_x_average, o_found));
                end else begin
                    oldest = centroids_due.pop_front();
                    if (o_x_average !== oldest.x_average) begin
                        log_mismatch($sformatf("x_average mismatch: expected %0d, got %0d",
                                               oldest.x_average, o_x_average));
                    end
                    if (o_found !== oldest.found) begin
                        log_mismatch($sformatf("found mismatch: expected %0d, got %0d",
                                               oldest.found, o_found));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    llc_pkg::CFG_FRAME_WIDTH: begin
                        reg_width = i_cfg_data[llc_pkg::EDGE_W-1:0];
                    end
                    llc_pkg::CFG_LEVEL_THRESHOLD: begin
                        reg_level = i_cfg_data[llc_pkg::RED_W-1:0];
                    end
                    llc_pkg::CFG_WINDOW_HALF: begin
                        reg_half = i_cfg_data[llc_pkg::HALF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = centroids_due.size();
    end

endmodule

FILE: tb/laser_line_column_centroid_tb.sv
// laser_line_column_centroid_tb: drives pixels and register writes into the
// centroid block with random gaps and stalls, and reports the verdict.
// Depends on llc_pkg, laser_line_column_centroid and llc_centroid_checker.
`timescale 1ns / 1ps

module laser_line_column_centroid_tb;

    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 740;
    localparam int WIDE_PIXELS    = 1100;

    logic                           i_clk;
    logic                           i_rst_n        = 1'b0;
    logic                           i_valid        = 1'b0;
    logic [llc_pkg::RED_W-1:0]      i_red_level    = '0;
    logic                           i_end_of_frame = 1'b0;
    logic                           i_ready        = 1'b0;
    logic                           i_cfg_valid    = 1'b0;
    logic [llc_pkg::CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [llc_pkg::CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                           o_ready;
    logic                           o_valid;
    logic [llc_pkg::AVG_W-1:0]      o_x_average;
    logic                           o_found;
    logic                           o_cfg_ready;

    int mismatches;
    int pending_results;
    int quiet_cycles   = 0;
    int sender_gap_max = 14;
    int reader_gap_max = 14;
    bit pressure_hold  = 1'b0;
    int level_now      = 100;
    int pixels_sent    = 0;

    laser_line_column_centroid u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red_level    (i_red_level),
        .i_end_of_frame (i_end_of_frame),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_x_average    (o_x_average),
        .o_found        (o_found),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    llc_centroid_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_red_level    (i_red_level),
        .i_end_of_frame (i_end_of_frame),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_x_average    (o_x_average),
        .o_found        (o_found),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("laser_line_column_centroid test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls, one long hold when asked
    initial begin
        int hold;
        wait (i_rst_n);
        forever begin
            if (pressure_hold) begin
                hold          = HOLD_CYCLES;
                pressure_hold = 1'b0;
            end else begin
                hold = $urandom_range(0, reader_gap_max);
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_pixel(input logic [llc_pkg::RED_W-1:0] red, input logic last);
        int gap;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_red_level    <= red;
        i_end_of_frame <= last;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [llc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [llc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int width, input int level, input int half);
        settle();
        write_reg(llc_pkg::CFG_FRAME_WIDTH, llc_pkg::CFG_DATA_W'(width));
        write_reg(llc_pkg::CFG_LEVEL_THRESHOLD, llc_pkg::CFG_DATA_W'(level));
        write_reg(llc_pkg::CFG_WINDOW_HALF, llc_pkg::CFG_DATA_W'(half));
        i_cfg_valid <= 1'b0;
        level_now = level;
    endtask

    // laser line drifting a little from row to row, dim background, stray noise, or all noise when scrambled
    task automatic send_frame(input int row_len, input int total, input bit close,
                              input bit scramble);
        int beam;
        int spread;
        int col;
        logic [llc_pkg::RED_W-1:0] red;
        beam   = $urandom_range(0, (row_len > 64 ? 64 : row_len) - 1);
        spread = $urandom_range(0, 2);
        for (int i = 0; i < total; i++) begin
            col = i % row_len;
            if (col == 0 && i != 0) begin
                beam = beam + int'($urandom_range(0, 4)) - 2;
                if (beam < 0) begin
                    beam = 0;
                end
                if (beam > row_len - 1) begin
                    beam = row_len - 1;
                end
            end
            if (scramble || $urandom_range(0, 15) == 0) begin
                red = llc_pkg::RED_W'($urandom_range(0, 255));
            end else if (col >= beam - spread && col <= beam + spread) begin
                red = (level_now == 255) ? 8'd255
                                         : llc_pkg::RED_W'($urandom_range(level_now + 1, 255));
            end else begin
                red = llc_pkg::RED_W'($urandom_range(0, level_now));
            end
            send_pixel(red, close && (i == total - 1));
        end
    endtask

    initial begin
        int sel;
        int width;
        int row_len;
        int level;
        int half;
        int frames;
        int total;
        int random_start;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: hit at column 0, level equal to threshold, just above
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd100, 1'b1);
        send_pixel(8'd101, 1'b1);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b1);

        // zero width acts as one column, zero half width closes the window
        configure(0, 0, 0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd1, 1'b1);

        // width above the limit, widest half width
        configure(8191, 254, 4095);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b1);

        // width shrinks while a frame is open
        configure(4, 0, 1);
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd9, 1'b0);
        configure(2, 0, 1);
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd9, 1'b1);

        // one-pixel frames against a long result stall
        configure(4, 0, 0);
        sender_gap_max = 0;
        pressure_hold  = 1'b1;
        repeat (40) send_pixel(8'd255, 1'b1);

        // one wide frame with the line far to the right
        configure(4096, 200, 30);
        sender_gap_max = 14;
        for (int i = 0; i < WIDE_PIXELS; i++) begin
            send_pixel((i >= 1050 && i < 1062) ? 8'd255
                                               : llc_pkg::RED_W'($urandom_range(0, 200)),
                       i == WIDE_PIXELS - 1);
        end

        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                width   = 0;
                row_len = 1;
            end else if (sel == 1) begin
                width   = $urandom_range(4097, 8191);
                row_len = 4096;
            end else if (sel == 2) begin
                width   = 4096;
                row_len = 4096;
            end else begin
                width   = $urandom_range(1, 48);
                row_len = width;
            end
            case ($urandom_range(0, 5))
                0:       level = 0;
                1:       level = 255;
                default: level = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 5))
                0:       half = 0;
                1:       half = 4095;
                2:       half = $urandom_range(0, 4095);
                default: half = $urandom_range(0, row_len < 4095 ? row_len : 4095);
            endcase
            configure(width, level, half);
            sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            reader_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            frames = $urandom_range(1, 5);
            for (int f = 0; f < frames; f++) begin
                total = (row_len <= 64)
                      ? $urandom_range(0, 5) * row_len + $urandom_range(1, row_len)
                      : $urandom_range(1, 64);
                send_frame(row_len, total, 1'b1, $urandom_range(0, 4) == 0);
            end
            // leave a frame open so the next settings land mid-frame
            if ($urandom_range(0, 3) == 0) begin
                total = (row_len <= 64) ? $urandom_range(1, 2 * row_len)
                                        : $urandom_range(1, 64);
                send_frame(row_len, total, 1'b0, 1'b0);
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("laser_line_column_centroid test passed");
        end else begin
            $display("laser_line_column_centroid test failed");
        end
        $finish;
    end

endmodule
